// File: design/tatm_pkg.sv
// Shared types and constants for the touch ADC trimmed-mean filter.
package tatm_pkg;

	// Field widths and fixed shifts.
	localparam int RAW_W            = 16;
	localparam int SAMPLE_W         = 13;
	localparam int SAMPLE_SHIFT     = 3;
	localparam int MEAN_SHIFT       = 3;
	localparam int DEF_SAMPLE_COUNT = 12;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = '0;

	// One raw converter response item.
	typedef struct packed {
		logic [RAW_W-1:0] raw_word;
		logic             axis;
	} sample_item_t;

	// One filtered result item.
	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered_value;
		logic                result_axis;
	} result_item_t;

	// Control from the sequencer to the rank unit.
	typedef struct packed {
		logic clear;
		logic en;
	} rank_ctl_t;

	// Two smallest and two largest samples seen in a sweep.
	typedef struct packed {
		logic [SAMPLE_W-1:0] min1;
		logic [SAMPLE_W-1:0] min2;
		logic [SAMPLE_W-1:0] max1;
		logic [SAMPLE_W-1:0] max2;
	} rank_stat_t;

endpackage

// File: design/tatm_sample_store.sv
// Burst sample memory with one write port and one registered read port.
module tatm_sample_store #(
	parameter int DEPTH = tatm_pkg::DEF_SAMPLE_COUNT,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [IDX_W-1:0]              wr_addr,
	input  logic [tatm_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [IDX_W-1:0]              rd_addr,
	output logic [tatm_pkg::SAMPLE_W-1:0] rd_data
);
	import tatm_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;

	// Write the incoming sample.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/tatm_rank_unit.sv
// Shared compare and accumulate unit: total plus two smallest and two largest samples.
module tatm_rank_unit #(
	parameter int TOT_W = tatm_pkg::SAMPLE_W + 4
) (
	input  logic                          clk,
	input  tatm_pkg::rank_ctl_t           ctl,
	input  logic [tatm_pkg::SAMPLE_W-1:0] sample,
	output tatm_pkg::rank_stat_t          stat,
	output logic [TOT_W-1:0]              total
);
	import tatm_pkg::*;

	rank_stat_t       stat_q;
	logic [TOT_W-1:0] total_q;

	// Insert one sample into the low pair and the high pair and add it to the total.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			stat_q.min1 <= SAMPLE_MAX;
			stat_q.min2 <= SAMPLE_MAX;
			stat_q.max1 <= SAMPLE_MIN;
			stat_q.max2 <= SAMPLE_MIN;
			total_q     <= '0;
		end else if (ctl.en) begin
			priority if (sample < stat_q.min1) begin
				stat_q.min1 <= sample;
				stat_q.min2 <= stat_q.min1;
			end else if (sample < stat_q.min2) begin
				stat_q.min2 <= sample;
			end
			priority if (sample > stat_q.max1) begin
				stat_q.max1 <= sample;
				stat_q.max2 <= stat_q.max1;
			end else if (sample > stat_q.max2) begin
				stat_q.max2 <= sample;
			end
			total_q <= total_q + TOT_W'(sample);
		end
	end

	assign stat  = stat_q;
	assign total = total_q;

endmodule

// File: design/touch_adc_trimmed_mean_unit.sv
// Top level of the touch ADC trimmed-mean filter: sequencer, store, rank unit, output register.
//
// Each accepted item is one raw converter word; its sample (word shifted right by three) is
// written to a small store, and the block is ready again on the next cycle. The item that
// completes a burst of SAMPLE_COUNT samples starts a sweep that reads the store one entry
// per cycle through a single compare and accumulate unit, which keeps the running total and
// the two smallest and two largest samples. That item therefore holds the input off through
// the sweep, drain and emit states, set by the one store read port and the shared rank unit,
// and while the previous result still waits to be taken. The result is the total minus the
// four outer samples, shifted right by three, tagged with the axis of the burst's first
// item, and waits in an output register until taken.
module touch_adc_trimmed_mean_unit #(
	parameter int SAMPLE_COUNT = tatm_pkg::DEF_SAMPLE_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  tatm_pkg::sample_item_t sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output tatm_pkg::result_item_t result
);
	import tatm_pkg::*;

	localparam int IDX_W = $clog2(SAMPLE_COUNT);
	localparam int TOT_W = SAMPLE_W + $clog2(SAMPLE_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    fill_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                rd_valid_s1;
	logic                axis_q;
	logic                out_valid_q;
	result_item_t        out_item_q;

	logic                take;
	logic                burst_done;
	logic                emit_go;
	logic [SAMPLE_W-1:0] new_sample;
	logic [SAMPLE_W-1:0] rd_data;
	rank_ctl_t           rank_ctl;
	rank_stat_t          rank_stat;
	logic [TOT_W-1:0]    total;
	logic [TOT_W-1:0]    trim_sum;

	// Input handshake and sample extraction.
	assign sample_stall = (state_q != ST_IDLE);
	assign take         = sample_valid && !sample_stall;
	assign burst_done   = take && (fill_q == LAST_IDX);
	assign new_sample   = SAMPLE_W'(sample.raw_word >> SAMPLE_SHIFT);

	// Burst fill count and axis of the first item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			axis_q <= 1'b0;
		end else if (take) begin
			if (fill_q == '0) begin
				axis_q <= sample.axis;
			end
			fill_q <= burst_done ? '0 : fill_q + 1'b1;
		end
	end

	tatm_sample_store #(
		.DEPTH (SAMPLE_COUNT),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (take),
		.wr_addr (fill_q),
		.wr_data (new_sample),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// Sweep sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SWEEP);
			unique case (state_q)
				ST_IDLE: begin
					if (burst_done) begin
						state_q  <= ST_SWEEP;
						rd_idx_q <= '0;
					end
				end
				ST_SWEEP: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rank_ctl.clear = burst_done;
	assign rank_ctl.en    = rd_valid_s1;

	tatm_rank_unit #(
		.TOT_W (TOT_W)
	) u_rank (
		.clk    (clk),
		.ctl    (rank_ctl),
		.sample (rd_data),
		.stat   (rank_stat),
		.total  (total)
	);

	// Drop the two smallest and the two largest samples from the total.
	assign trim_sum = total - TOT_W'(rank_stat.min1) - TOT_W'(rank_stat.min2)
		- TOT_W'(rank_stat.max1) - TOT_W'(rank_stat.max2);

	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !result_stall);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_item_q.filtered_value <= SAMPLE_W'(trim_sum >> MEAN_SHIFT);
			out_item_q.result_axis    <= axis_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_item_q;

endmodule

// File: design/tatm_checker.sv
// Port-level checks for the touch ADC trimmed-mean filter, bound to the top level.
module tatm_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   sample_valid,
	input logic                   sample_stall,
	input tatm_pkg::sample_item_t sample,
	input logic                   result_valid,
	input logic                   result_stall,
	input tatm_pkg::result_item_t result
);
	import tatm_pkg::*;

	// A stalled input item stays offered and holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample))
		else $error("stalled input item changed");

	// A stalled result stays and holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A new result appears only after a sweep during which input was held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall, 1) && $past(sample_stall, 12))
		else $error("result without a preceding sweep");

	// Input is released only once the result of the sweep has been loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_stall) |-> result_valid)
		else $error("input released without a pending result");

endmodule

bind touch_adc_trimmed_mean_unit tatm_checker u_tatm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample       (sample),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: tb/tb_touch_adc_trimmed_mean_unit.sv
// Self-checking testbench for the touch ADC trimmed-mean filter unit.
`timescale 1ns / 1ps

module tb_touch_adc_trimmed_mean_unit;
	import tatm_pkg::*;

	localparam int BURST_LEN   = DEF_SAMPLE_COUNT;
	localparam int TRIM_EACH   = 2;
	localparam int HOLD_CYCLES = 200;
	localparam int STUCK_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	logic         clk;
	logic         arst_n;
	logic         sample_valid;
	logic         sample_stall;
	sample_item_t sample;
	logic         result_valid;
	logic         result_stall;
	result_item_t result;

	// Predictor state: the burst being collected and the means still owed.
	logic [SAMPLE_W-1:0] burst_samples [BURST_LEN];
	int                  burst_fill;
	logic                burst_axis_q;
	result_item_t        pending_means [$];

	int fail_count;
	int stuck_cycles;
	bit idle_enable;
	bit hold_go;
	int hold_left;

	touch_adc_trimmed_mean_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Sort the collected burst, drop the two lowest and two highest, average the middle eight.
	function automatic logic [SAMPLE_W-1:0] trimmed_mean_of_burst();
		logic [SAMPLE_W-1:0] ordered [BURST_LEN];
		logic [SAMPLE_W-1:0] v;
		logic [16:0]         total;
		int                  i;
		int                  j;
		for (i = 0; i < BURST_LEN; i++)
			ordered[i] = burst_samples[i];
		for (i = 1; i < BURST_LEN; i++) begin
			v = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > v) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = v;
		end
		total = '0;
		for (i = TRIM_EACH; i < BURST_LEN - TRIM_EACH; i++)
			total += ordered[i];
		return SAMPLE_W'(total >> MEAN_SHIFT);
	endfunction

	// Add one accepted item to the burst; a full burst owes one result.
	function automatic void absorb_sample(sample_item_t it);
		result_item_t owed;
		if (burst_fill == 0)
			burst_axis_q = it.axis;
		burst_samples[burst_fill] = SAMPLE_W'(it.raw_word >> SAMPLE_SHIFT);
		burst_fill++;
		if (burst_fill == BURST_LEN) begin
			burst_fill = 0;
			owed.filtered_value = trimmed_mean_of_burst();
			owed.result_axis = burst_axis_q;
			pending_means.push_back(owed);
		end
	endfunction

	// Watch the input channel and predict every accepted item.
	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall)
			absorb_sample(sample);
	end

	// Compare each accepted result with the oldest owed mean.
	always @(posedge clk) begin
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_means.size() == 0) begin
				$error("unexpected result item: filtered_value %0d result_axis %0d",
					result.filtered_value, result.result_axis);
				fail_count++;
			end else begin
				want = pending_means.pop_front();
				if (result.filtered_value !== want.filtered_value) begin
					$error("filtered_value: expected %0d, actual %0d",
						want.filtered_value, result.filtered_value);
					fail_count++;
				end
				if (result.result_axis !== want.result_axis) begin
					$error("result_axis: expected %0d, actual %0d",
						want.result_axis, result.result_axis);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= idle_enable && ($urandom_range(0, 99) < 7);
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb_touch_adc_trimmed_mean_unit NOT OK");
				$finish;
			end
		end
	end

	// Offer one item, with an occasional random gap first, and return at the edge it is taken.
	task automatic send_item(input sample_item_t it);
		int gap;
		gap = 0;
		if (idle_enable)
			while ($urandom_range(0, 99) < 7)
				gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= it;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	// Random raw word: mostly clustered around the burst's touch point, some spread, some extremes.
	function automatic logic [RAW_W-1:0] pick_raw_word(logic [RAW_W-1:0] center);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return center + RAW_W'($urandom_range(0, 255)) - RAW_W'(128);
		else if (roll < 85)
			return RAW_W'($urandom);
		else if (roll < 92)
			return '1;
		else if (roll < 96)
			return RAW_W'($urandom_range(0, 7));
		else
			return {SAMPLE_MAX, 3'($urandom_range(0, 7))};
	endfunction

	// Whole bursts with random content; the axis now and then flips inside a burst.
	task automatic send_random_bursts(input int bursts);
		sample_item_t    it;
		logic [RAW_W-1:0] center;
		logic             ax;
		int               b;
		int               k;
		for (b = 0; b < bursts; b++) begin
			center = RAW_W'($urandom);
			ax = 1'($urandom_range(0, 1));
			for (k = 0; k < BURST_LEN; k++) begin
				it.raw_word = pick_raw_word(center);
				it.axis = ($urandom_range(0, 9) == 0) ? !ax : ax;
				send_item(it);
			end
		end
	endtask

	// Full-scale burst: the largest possible mean, with the axis toggling after the first item.
	task automatic test_full_scale_burst();
		sample_item_t it;
		int           k;
		for (k = 0; k < BURST_LEN; k++) begin
			it.raw_word = '1;
			it.axis = (k % 2 == 1);
			send_item(it);
		end
	endtask

	// Unordered burst with both extremes and stray low bits, to exercise sorting and trimming.
	task automatic test_ordering_burst();
		logic [RAW_W-1:0] words [BURST_LEN] = '{16'h8007, 16'hFFFF, 16'h0000, 16'h0007,
			16'h7FF8, 16'h4000, 16'h2008, 16'h1000, 16'hFFF8, 16'h0008, 16'h5555, 16'hAAAA};
		logic             axes [BURST_LEN] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
			1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		sample_item_t     it;
		int               k;
		for (k = 0; k < BURST_LEN; k++) begin
			it.raw_word = words[k];
			it.axis = axes[k];
			send_item(it);
		end
	endtask

	// Receiver holds off while the sender keeps going, so the output fills and the input stalls.
	task automatic test_output_backpressure();
		hold_go = 1'b1;
		send_random_bursts(3);
	endtask

	// Sender stops mid-burst until every owed result has come out, then resumes.
	task automatic test_drain_pause();
		sample_item_t it;
		int           k;
		for (k = 0; k < 5; k++) begin
			it.raw_word = RAW_W'($urandom);
			it.axis = 1'($urandom_range(0, 1));
			send_item(it);
		end
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0)
			@(posedge clk);
		for (k = 5; k < BURST_LEN; k++) begin
			it.raw_word = RAW_W'($urandom);
			it.axis = 1'($urandom_range(0, 1));
			send_item(it);
		end
		send_random_bursts(19);
	endtask

	// Back-to-back traffic with no idling on either side.
	task automatic test_no_idle_stretch();
		idle_enable = 1'b0;
		send_random_bursts(25);
		idle_enable = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		result_stall = 1'b0;
		burst_fill = 0;
		burst_axis_q = 1'b0;
		fail_count = 0;
		stuck_cycles = 0;
		idle_enable = 1'b1;
		hold_go = 1'b0;
		hold_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_scale_burst();
		test_ordering_burst();
		send_random_bursts(40);
		test_output_backpressure();
		test_drain_pause();
		test_no_idle_stretch();

		// Let every owed result come out, then allow for a late extra one.
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_means.size() == 0) begin
			$display("tb_touch_adc_trimmed_mean_unit OK");
		end else begin
			$display("tb_touch_adc_trimmed_mean_unit NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
design/tatm_pkg.sv
design/tatm_sample_store.sv
design/tatm_rank_unit.sv
design/touch_adc_trimmed_mean_unit.sv
design/tatm_checker.sv
tb/tb_touch_adc_trimmed_mean_unit.sv
